/* hdl/usf_pkg.sv */
`timescale 1ns / 1ps

package usf_pkg;

  localparam int unsigned CHARS_PER_PKG = 6;
  localparam int unsigned SLOT_BYTES    = 4 * CHARS_PER_PKG;
  localparam int unsigned PKG_BYTES     = SLOT_BYTES + 8;
  localparam int unsigned POS_W         = $clog2(PKG_BYTES);
  localparam int unsigned SLOT_IDX_W    = $clog2(SLOT_BYTES);
  localparam int unsigned CHAR_CNT_W    = $clog2(CHARS_PER_PKG + 1);

  localparam int unsigned QDEPTH        = 2;
  localparam int unsigned QPTR_W        = $clog2(QDEPTH);
  localparam int unsigned QCNT_W        = $clog2(QDEPTH + 1);

  localparam int unsigned ADDR_W        = 3;
  localparam int unsigned DATA_W        = 32;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_ONE  = 3'd1;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  localparam logic REG_SENDER_ID = 1'b0;

  typedef struct packed {
    logic [7:0]            data;
    logic [SLOT_IDX_W-1:0] idx;
    logic                  store;
    logic                  emit_pkg;
    logic                  emit_term;
    logic                  err;
  } usf_op_t;

  typedef struct packed {
    logic [7:0] package_byte;
    logic [4:0] byte_position;
    logic       last_of_package;
    logic       last_of_message;
    logic       decode_error;
  } usf_result_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [3:0] nib;
    logic [2:0] len;
    nib = b[7:4];
    unique case (nib) inside
      [4'h0:4'h7]: len = LEN_ONE;
      4'hC, 4'hD:  len = LEN_TWO;
      4'hE:        len = LEN_THREE;
      4'hF:        len = LEN_FOUR;
      default:     len = LEN_NONE;
    endcase
    return len;
  endfunction

  function automatic logic [31:0] sext8(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

endpackage

/* hdl/usf_front.sv */
`timescale 1ns / 1ps

module usf_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  input  logic [7:0]     text_byte_i,
  input  logic           has_byte_i,
  input  logic           end_of_message_i,
  input  logic           q_full_i,
  output logic           op_valid_o,
  output usf_pkg::usf_op_t op_o
);
  import usf_pkg::*;

  logic [CHAR_CNT_W-1:0] cc_q, cc_d, cc_inc;
  logic [1:0]            bic_q, bic_d, bic_cur;
  logic [2:0]            clen_q, clen_d, len_eff, bic_inc;
  logic                  drop_q, drop_d;
  logic                  accept;
  usf_op_t               op;

  assign accept = push && !q_full_i;

  always_comb begin
    cc_d    = cc_q;
    bic_d   = bic_q;
    clen_d  = clen_q;
    drop_d  = drop_q;
    op      = '0;
    len_eff = clen_q;
    bic_cur = bic_q;
    bic_inc = '0;
    cc_inc  = cc_q + CHAR_CNT_W'(1);
    if (accept) begin
      if (has_byte_i && !drop_q) begin
        if (clen_q == LEN_NONE) begin
          len_eff = lead_length(text_byte_i);
          bic_cur = 2'd0;
        end
        if (len_eff == LEN_NONE) begin
          op.err = 1'b1;
          cc_d   = '0;
          bic_d  = '0;
          clen_d = LEN_NONE;
          drop_d = 1'b1;
        end else begin
          op.store = 1'b1;
          op.data  = text_byte_i;
          op.idx   = SLOT_IDX_W'({cc_q, bic_cur});
          bic_inc  = {1'b0, bic_cur} + 3'd1;
          if (bic_inc >= len_eff) begin
            bic_d  = '0;
            clen_d = LEN_NONE;
            if (cc_inc >= CHAR_CNT_W'(CHARS_PER_PKG)) begin
              op.emit_pkg = 1'b1;
              cc_d        = '0;
            end else begin
              cc_d = cc_inc;
            end
          end else begin
            bic_d  = bic_inc[1:0];
            clen_d = len_eff;
          end
        end
      end
      if (end_of_message_i) begin
        if (drop_d) begin
          drop_d = 1'b0;
        end else begin
          if (cc_d != '0 || clen_d != LEN_NONE) begin
            op.emit_pkg = 1'b1;
          end
          op.emit_term = 1'b1;
        end
        cc_d   = '0;
        bic_d  = '0;
        clen_d = LEN_NONE;
      end
    end
  end

  assign op_o       = op;
  assign op_valid_o = op.err || op.store || op.emit_pkg || op.emit_term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q   <= '0;
      bic_q  <= '0;
      clen_q <= LEN_NONE;
      drop_q <= 1'b0;
    end else begin
      cc_q   <= cc_d;
      bic_q  <= bic_d;
      clen_q <= clen_d;
      drop_q <= drop_d;
    end
  end

endmodule

/* hdl/usf_queue.sv */
`timescale 1ns / 1ps

module usf_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  usf_pkg::usf_op_t wr_op_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic             valid_o,
  output usf_pkg::usf_op_t rd_op_o
);
  import usf_pkg::*;

  usf_op_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  cnt_q;
  logic               do_wr, do_rd;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign rd_op_o = mem_q[rd_ptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* hdl/usf_back.sv */
`timescale 1ns / 1ps

module usf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 op_valid_i,
  input  usf_pkg::usf_op_t     op_i,
  output logic                 op_pop_o,
  input  logic [31:0]          sender_id_i,
  input  logic                 pop,
  output logic                 empty,
  output usf_pkg::usf_result_t result_o
);
  import usf_pkg::*;

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_EMIT = 2'b10
  } usf_back_state_e;

  usf_back_state_e   st_q, st_d;
  logic [7:0]        slot_q [SLOT_BYTES];
  logic [7:0]        slot_d [SLOT_BYTES];
  logic [31:0]       chk_q, chk_d;
  logic [POS_W-1:0]  pos_q, pos_d, pos_off;
  logic [POS_W+4:0]  pos_ext;
  logic              cur_term_q, cur_term_d;
  logic              term_next_q, term_next_d;
  logic              out_vld_q, out_vld_d;
  usf_result_t       out_q, out_d;
  logic              out_free, last_pos;
  logic [7:0]        cur_byte;

  assign out_free = !out_vld_q || pop;
  assign last_pos = (pos_q == POS_W'(PKG_BYTES - 1));
  assign pos_off  = pos_q - POS_W'(4);
  assign pos_ext  = {5'd0, pos_q};

  always_comb begin
    if (pos_q < POS_W'(4)) begin
      cur_byte = sender_id_i[8*pos_q[1:0] +: 8];
    end else if (pos_q >= POS_W'(PKG_BYTES - 4)) begin
      cur_byte = chk_q[8*pos_q[1:0] +: 8];
    end else begin
      cur_byte = slot_q[pos_off[SLOT_IDX_W-1:0]];
    end
  end

  always_comb begin
    st_d        = st_q;
    slot_d      = slot_q;
    chk_d       = chk_q;
    pos_d       = pos_q;
    cur_term_d  = cur_term_q;
    term_next_d = term_next_q;
    out_vld_d   = out_vld_q && !pop;
    out_d       = out_q;
    op_pop_o    = 1'b0;
    unique case (st_q)
      BK_IDLE: begin
        if (op_valid_i && out_free) begin
          op_pop_o = 1'b1;
          if (op_i.err) begin
            out_vld_d             = 1'b1;
            out_d.package_byte    = 8'd0;
            out_d.byte_position   = 5'd0;
            out_d.last_of_package = 1'b0;
            out_d.last_of_message = 1'b1;
            out_d.decode_error    = 1'b1;
            for (int i = 0; i < SLOT_BYTES; i++) begin
              slot_d[i] = 8'd0;
            end
            chk_d = '0;
          end else begin
            if (op_i.store) begin
              slot_d[op_i.idx] = op_i.data;
              chk_d            = chk_q + sext8(op_i.data);
            end
            pos_d = '0;
            if (op_i.emit_pkg) begin
              st_d        = BK_EMIT;
              cur_term_d  = 1'b0;
              term_next_d = op_i.emit_term;
            end else if (op_i.emit_term) begin
              for (int i = 0; i < SLOT_BYTES; i++) begin
                slot_d[i] = 8'd0;
              end
              slot_d[0]   = NEWLINE_BYTE;
              chk_d       = {24'd0, NEWLINE_BYTE};
              st_d        = BK_EMIT;
              cur_term_d  = 1'b1;
              term_next_d = 1'b0;
            end
          end
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          out_vld_d             = 1'b1;
          out_d.package_byte    = cur_byte;
          out_d.byte_position   = pos_ext[4:0];
          out_d.last_of_package = last_pos;
          out_d.last_of_message = last_pos && cur_term_q;
          out_d.decode_error    = 1'b0;
          if (pos_q < POS_W'(4)) begin
            chk_d = chk_q + sext8(cur_byte);
          end
          pos_d = pos_q + POS_W'(1);
          if (last_pos) begin
            pos_d = '0;
            for (int i = 0; i < SLOT_BYTES; i++) begin
              slot_d[i] = 8'd0;
            end
            chk_d = '0;
            if (term_next_q) begin
              slot_d[0]   = NEWLINE_BYTE;
              chk_d       = {24'd0, NEWLINE_BYTE};
              cur_term_d  = 1'b1;
              term_next_d = 1'b0;
            end else begin
              st_d = BK_IDLE;
            end
          end
        end
      end
      default: begin
        st_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BK_IDLE;
      for (int i = 0; i < SLOT_BYTES; i++) begin
        slot_q[i] <= 8'd0;
      end
      chk_q       <= '0;
      pos_q       <= '0;
      cur_term_q  <= 1'b0;
      term_next_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      st_q        <= st_d;
      slot_q      <= slot_d;
      chk_q       <= chk_d;
      pos_q       <= pos_d;
      cur_term_q  <= cur_term_d;
      term_next_q <= term_next_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign empty    = !out_vld_q;
  assign result_o = out_q;

endmodule

/* hdl/utf8_slot_package_framer.sv */
`timescale 1ns / 1ps
// Framer that packs UTF-8 message text into fixed 32-byte packages.
// Input channel: push/full queue interface carrying text_byte_i, has_byte_i
// and end_of_message_i; one beat is taken whenever the internal two-entry
// op queue has room.
// Result channel: empty/pop queue interface; the oldest result byte sits on
// the ports while empty is low and leaves on a beat with pop high.
// Each package streams out one result byte a cycle while pop keeps up, once
// its op has left the queue; a message end with pending text yields 64
// bytes (partial package then terminator). An idle back end takes a
// completing beat's op into its state register, then registers the first
// byte. Sustained input rate is bound by the package stream. An invalid
// lead byte gives a single error beat, registered as its op leaves the
// queue, which waits for any current package to go out. A stall on pop
// holds the output register; the back end then holds, the op queue fills
// and full rises, with no beat lost. Reset clears all slots, counters and
// the sender id; no clearing pass. Users write sender_id at byte address
// 0 of the APB port only while idle; the block does not enforce it.

module utf8_slot_package_framer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 text_byte_i,
  input  logic                       has_byte_i,
  input  logic                       end_of_message_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [7:0]                 package_byte_o,
  output logic [4:0]                 byte_position_o,
  output logic                       last_of_package_o,
  output logic                       last_of_message_o,
  output logic                       decode_error_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [usf_pkg::ADDR_W-1:0] paddr,
  input  logic [usf_pkg::DATA_W-1:0] pwdata,
  output logic [usf_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import usf_pkg::*;

  logic [31:0]  sender_id_q;
  logic         wr_en;
  logic         op_valid, q_full, q_valid, q_pop;
  usf_op_t      op, q_op;
  usf_result_t  result;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_SENDER_ID) ? sender_id_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sender_id_q <= '0;
    end else if (wr_en && paddr[2] == REG_SENDER_ID) begin
      sender_id_q <= pwdata;
    end
  end

  assign full = q_full;

  usf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .text_byte_i      (text_byte_i),
    .has_byte_i       (has_byte_i),
    .end_of_message_i (end_of_message_i),
    .q_full_i         (q_full),
    .op_valid_o       (op_valid),
    .op_o             (op)
  );

  usf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (op_valid),
    .wr_op_i (op),
    .full_o  (q_full),
    .rd_i    (q_pop),
    .valid_o (q_valid),
    .rd_op_o (q_op)
  );

  usf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_i        (q_op),
    .op_pop_o    (q_pop),
    .sender_id_i (sender_id_q),
    .pop         (pop),
    .empty       (empty),
    .result_o    (result)
  );

  assign package_byte_o    = result.package_byte;
  assign byte_position_o   = result.byte_position;
  assign last_of_package_o = result.last_of_package;
  assign last_of_message_o = result.last_of_message;
  assign decode_error_o    = result.decode_error;

endmodule

/* hdl/usf_checker.sv */
`timescale 1ns / 1ps

module usf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] package_byte_o,
  input logic [4:0] byte_position_o,
  input logic       last_of_package_o,
  input logic       last_of_message_o,
  input logic       decode_error_o
);
  import usf_pkg::*;

  localparam logic [POS_W+4:0] LAST_POS_EXT = (POS_W + 5)'(PKG_BYTES - 1);

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(package_byte_o) && $stable(byte_position_o)))
    else $error("stalled result changed");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_of_package_o) |-> (byte_position_o == LAST_POS_EXT[4:0]))
    else $error("package end at wrong position");

  a_error_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && decode_error_o) |->
      (package_byte_o == 8'd0 && byte_position_o == 5'd0 && last_of_message_o
       && !last_of_package_o))
    else $error("malformed error beat");

  a_msg_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_of_message_o && !decode_error_o) |-> last_of_package_o)
    else $error("message end inside a package");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_of_package_o && !decode_error_o) |=>
      (empty || byte_position_o == $past(byte_position_o) + 5'd1))
    else $error("byte position skipped");

endmodule

bind utf8_slot_package_framer usf_checker u_checker (.*);
